/* rtl/vrce_pkg.sv */
// Shared types and constants for the vehicle route cost evaluator.
// No dependencies; every other file in rtl/ imports this package.
package vrce_pkg;

    localparam int MAX_CITIES_DEF = 256;
    localparam int DIST_BITS_DEF  = 16;
    localparam int LOAD_BITS_DEF  = 16;

    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = 3;
    localparam int CAP_W       = 16;
    localparam int VAL_W       = 32;

    localparam logic [1:0] ACT_DIST   = 2'd0;
    localparam logic [1:0] ACT_DEMAND = 2'd1;
    localparam logic [1:0] ACT_VISIT  = 2'd2;

    localparam logic KIND_STOP  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] value;
        logic             fin;
    } res_item_t;

    typedef struct packed {
        res_item_t [MAX_RESULTS-1:0] slot;
        logic [RES_CNT_W-1:0]        count;
    } res_bundle_t;

endpackage

/* rtl/vrce_tables.sv */
// Distance and demand tables: synchronous memories, one write port each,
// two read ports on the distance table, registered read data. Uses vrce_pkg.
module vrce_tables #(
    parameter int MAX_CITIES = vrce_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = vrce_pkg::DIST_BITS_DEF,
    parameter int LOAD_BITS  = vrce_pkg::LOAD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 dist_we,
    input  logic [2*$clog2(MAX_CITIES)-1:0]      dist_waddr,
    input  logic [DIST_BITS-1:0]                 dist_wdata,
    input  logic                                 dist_re,
    input  logic [2*$clog2(MAX_CITIES)-1:0]      dist_raddr_a,
    input  logic [2*$clog2(MAX_CITIES)-1:0]      dist_raddr_b,
    output logic [DIST_BITS-1:0]                 dist_rdata_a,
    output logic [DIST_BITS-1:0]                 dist_rdata_b,
    input  logic                                 dem_we,
    input  logic [$clog2(MAX_CITIES)-1:0]        dem_waddr,
    input  logic [LOAD_BITS-1:0]                 dem_wdata,
    input  logic                                 dem_re,
    input  logic [$clog2(MAX_CITIES)-1:0]        dem_raddr,
    output logic [LOAD_BITS-1:0]                 dem_rdata
);
    import vrce_pkg::*;

    localparam int CITY_W     = $clog2(MAX_CITIES);
    localparam int DIST_DEPTH = 1 << (2 * CITY_W);
    localparam int DEM_DEPTH  = 1 << CITY_W;

    logic [DIST_BITS-1:0] dist_mem [DIST_DEPTH];
    logic [LOAD_BITS-1:0] dem_mem  [DEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re)
        begin
            dist_rdata_a <= dist_mem[dist_raddr_a];
            dist_rdata_b <= dist_mem[dist_raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dem_we)
        begin
            dem_mem[dem_waddr] <= dem_wdata;
        end
        if (dem_re)
        begin
            dem_rdata <= dem_mem[dem_raddr];
        end
    end

endmodule

/* rtl/vrce_result_buf.sv */
// Result buffer: takes a bundle of up to five results at once and drains
// them one per cycle to the output stream while out_ready is high. Uses vrce_pkg.
module vrce_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vrce_pkg::res_bundle_t bundle,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vrce_pkg::res_item_t  out_item
);
    import vrce_pkg::*;

    res_item_t [MAX_RESULTS-1:0] slot_reg;
    res_item_t [MAX_RESULTS-1:0] slot_next;
    logic [RES_CNT_W-1:0]        count_reg;
    logic [RES_CNT_W-1:0]        count_next;
    logic                        pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[0];
    assign pop       = out_valid && out_ready;
    // accept a new bundle once the last held result leaves
    assign free      = (count_reg == '0) || ((count_reg == RES_CNT_W'(1)) && pop);

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (push)
        begin
            slot_next  = bundle.slot;
            count_next = bundle.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            count_next = count_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/vrce_core.sv */
// Route sequencer: decodes requests, drives the table memories, tracks load
// and running distance, and builds the result bundle. Uses vrce_pkg.
module vrce_core #(
    parameter int MAX_CITIES = vrce_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = vrce_pkg::DIST_BITS_DEF,
    parameter int LOAD_BITS  = vrce_pkg::LOAD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           in_action,
    input  logic [7:0]                           in_city_a,
    input  logic [7:0]                           in_city_b,
    input  logic [15:0]                          in_entry_value,
    input  logic                                 in_route_end,
    input  logic                                 cfg_valid,
    input  logic [vrce_pkg::CAP_W-1:0]           cfg_data,
    output logic                                 dist_we,
    output logic [2*$clog2(MAX_CITIES)-1:0]      dist_waddr,
    output logic [DIST_BITS-1:0]                 dist_wdata,
    output logic                                 dist_re,
    output logic [2*$clog2(MAX_CITIES)-1:0]      dist_raddr_a,
    output logic [2*$clog2(MAX_CITIES)-1:0]      dist_raddr_b,
    input  logic [DIST_BITS-1:0]                 dist_rdata_a,
    input  logic [DIST_BITS-1:0]                 dist_rdata_b,
    output logic                                 dem_we,
    output logic [$clog2(MAX_CITIES)-1:0]        dem_waddr,
    output logic [LOAD_BITS-1:0]                 dem_wdata,
    output logic                                 dem_re,
    output logic [$clog2(MAX_CITIES)-1:0]        dem_raddr,
    input  logic [LOAD_BITS-1:0]                 dem_rdata,
    input  logic                                 buf_free,
    output logic                                 buf_push,
    output vrce_pkg::res_bundle_t                buf_bundle
);
    import vrce_pkg::*;

    localparam int CITY_W = $clog2(MAX_CITIES);
    localparam int SUM_W  = (LOAD_BITS > CAP_W ? LOAD_BITS : CAP_W) + 1;
    localparam int ACC_W  = VAL_W + 2;
    localparam int EXT_W  = DIST_BITS + 1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LEG   = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    localparam logic [CITY_W-1:0] DEPOT = '0;

    // city index reduced modulo the table size
    logic [CITY_W-1:0] city_mod [256];
    for (genvar i = 0; i < 256; i++)
    begin : g_mod
        assign city_mod[i] = CITY_W'(i % MAX_CITIES);
    end

    logic [1:0]         phase_reg, phase_next;
    logic [CITY_W-1:0]  city_reg;
    logic               end_reg;
    logic               over_reg;
    logic [CITY_W-1:0]  prev_reg;
    logic [LOAD_BITS-1:0] load_reg, load_next;
    logic [VAL_W-1:0]   dist_reg, dist_next;
    logic               lsd_reg, lsd_next;
    logic               started_reg, started_next;
    logic [CAP_W-1:0]   cap_reg;

    logic [CITY_W-1:0]  ca, cb;
    logic               in_fire, visit_fire, close_go;
    logic               depot;
    logic [SUM_W-1:0]   load_sum;
    logic               fits;
    logic [DIST_BITS-1:0] leg_dist;
    logic [ACC_W-1:0]   leg_acc;
    logic [EXT_W-1:0]   extra;
    logic [ACC_W-1:0]   close_acc;
    logic [VAL_W-1:0]   close_total;
    logic               lsd0, lsd1;
    res_item_t [MAX_RESULTS-1:0] cand;
    logic [MAX_RESULTS-1:0]      cand_en;
    logic [RES_CNT_W-1:0]        fill;

    assign ca = city_mod[in_city_a];
    assign cb = city_mod[in_city_b];

    assign close_go   = (phase_reg == PH_CLOSE) && buf_free;
    assign in_ready   = (phase_reg == PH_IDLE) || close_go;
    assign in_fire    = in_valid && in_ready;
    assign visit_fire = in_fire && (in_action == ACT_VISIT);

    // table writes
    assign dist_we    = in_fire && (in_action == ACT_DIST);
    assign dist_waddr = {ca, cb};
    assign dist_wdata = DIST_BITS'(in_entry_value);
    assign dem_we     = in_fire && (in_action == ACT_DEMAND);
    assign dem_waddr  = ca;
    assign dem_wdata  = LOAD_BITS'(in_entry_value);

    // issue leg reads on accept, return and closing reads in the leg phase
    assign dem_re    = visit_fire;
    assign dem_raddr = ca;
    assign dist_re   = visit_fire || (phase_reg == PH_LEG);
    always_comb
    begin
        if (phase_reg == PH_LEG)
        begin
            dist_raddr_a = {DEPOT, city_reg};
            dist_raddr_b = {city_reg, DEPOT};
        end
        else
        begin
            dist_raddr_a = {prev_reg, ca};
            dist_raddr_b = {prev_reg, DEPOT};
        end
    end

    // leg phase: capacity check and first distance
    assign depot    = (city_reg == DEPOT);
    assign load_sum = SUM_W'(load_reg) + SUM_W'(dem_rdata);
    assign fits     = (load_sum <= SUM_W'(cap_reg));
    assign leg_dist = (depot || !fits) ? dist_rdata_b : dist_rdata_a;
    assign leg_acc  = ACC_W'(dist_reg) + ACC_W'(leg_dist);

    // closing phase: leg out of the depot and the return at route end
    assign extra = (over_reg ? EXT_W'(dist_rdata_a) : '0)
                 + (end_reg ? EXT_W'(dist_rdata_b) : '0);
    assign close_acc   = ACC_W'(dist_reg) + ACC_W'(extra);
    assign close_total = (close_acc[ACC_W-1:VAL_W] != '0) ? '1 : close_acc[VAL_W-1:0];

    assign lsd0 = started_reg ? lsd_reg : 1'b1;
    assign lsd1 = depot ? 1'b1 : 1'b0;

    always_comb
    begin
        cand[0] = '{kind: KIND_STOP,  value: '0, fin: 1'b0};
        cand[1] = '{kind: KIND_STOP,  value: '0, fin: 1'b0};
        cand[2] = '{kind: KIND_STOP,  value: VAL_W'(city_reg), fin: 1'b0};
        cand[3] = '{kind: KIND_STOP,  value: '0, fin: 1'b0};
        cand[4] = '{kind: KIND_TOTAL, value: close_total, fin: 1'b1};
        cand_en[0] = !started_reg;
        cand_en[1] = depot ? !lsd0 : (over_reg && !lsd0);
        cand_en[2] = !depot;
        cand_en[3] = end_reg && !lsd1;
        cand_en[4] = end_reg;
    end

    // pack the enabled results into consecutive slots
    always_comb
    begin
        buf_bundle.slot = '0;
        fill = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (cand_en[i])
            begin
                buf_bundle.slot[fill] = cand[i];
                fill = fill + RES_CNT_W'(1);
            end
        end
        buf_bundle.count = fill;
    end

    assign buf_push = close_go;

    always_comb
    begin
        phase_next   = phase_reg;
        load_next    = load_reg;
        dist_next    = dist_reg;
        lsd_next     = lsd_reg;
        started_next = started_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (visit_fire)
                begin
                    phase_next = PH_LEG;
                end
            end
            PH_LEG:
            begin
                phase_next = PH_CLOSE;
                dist_next  = (leg_acc[ACC_W-1:VAL_W] != '0) ? '1 : leg_acc[VAL_W-1:0];
                if (depot)
                begin
                    load_next = '0;
                end
                else if (fits)
                begin
                    load_next = LOAD_BITS'(load_sum);
                end
                else
                begin
                    load_next = dem_rdata;
                end
            end
            PH_CLOSE:
            begin
                if (close_go)
                begin
                    phase_next = visit_fire ? PH_LEG : PH_IDLE;
                    if (end_reg)
                    begin
                        load_next    = '0;
                        dist_next    = '0;
                        lsd_next     = 1'b1;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        dist_next    = close_total;
                        lsd_next     = lsd1;
                        started_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            prev_reg    <= '0;
            load_reg    <= '0;
            dist_reg    <= '0;
            lsd_reg     <= 1'b1;
            started_reg <= 1'b0;
            cap_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            load_reg    <= load_next;
            dist_reg    <= dist_next;
            lsd_reg     <= lsd_next;
            started_reg <= started_next;
            if (visit_fire)
            begin
                // the next visit reads from here; a route end returns to the depot
                prev_reg <= in_route_end ? DEPOT : ca;
            end
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // item payload, held through the leg and closing phases
    always_ff @(posedge clk)
    begin
        if (visit_fire)
        begin
            city_reg <= ca;
            end_reg  <= in_route_end;
        end
        if (phase_reg == PH_LEG)
        begin
            over_reg <= !depot && !fits;
        end
    end

endmodule

/* rtl/vehicle_route_cost_evaluator.sv */
// Top level of the vehicle route cost evaluator: request stream in, stop
// and total stream out, capacity register. Uses vrce_pkg, vrce_tables,
// vrce_core and vrce_result_buf.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tuser action, tdata cities+value,
//                                                   tlast route end
//   m_axis    out        m_axis_tvalid/tready      tuser kind, tdata value, tlast final
//   cfg       in         cfg_valid/cfg_ready       cfg_data vehicle capacity
//
// A visit first reads the demand and two distance entries, then in the leg
// phase reads the two further distance entries from the dual-read distance
// memory; the next request can be accepted in the visit's closing cycle.
// Results leave one per cycle while m_axis_tready is high; a visit's closing
// cycle holds until the result buffer is empty or its last result leaves in
// that same cycle. Reset clears route state and the capacity; the tables are
// not cleared. cfg_ready is always high.
module vehicle_route_cost_evaluator #(
    parameter int MAX_CITIES = vrce_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = vrce_pkg::DIST_BITS_DEF,
    parameter int LOAD_BITS  = vrce_pkg::LOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // city_a[7:0], city_b[15:8], entry_value[31:16]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    input  logic        s_axis_tlast,   // route_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_value[31:0]
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,   // final_flag
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import vrce_pkg::*;

    localparam int CITY_W = $clog2(MAX_CITIES);

    logic                  dist_we, dist_re, dem_we, dem_re;
    logic [2*CITY_W-1:0]   dist_waddr, dist_raddr_a, dist_raddr_b;
    logic [DIST_BITS-1:0]  dist_wdata, dist_rdata_a, dist_rdata_b;
    logic [CITY_W-1:0]     dem_waddr, dem_raddr;
    logic [LOAD_BITS-1:0]  dem_wdata, dem_rdata;
    logic                  buf_free, buf_push;
    res_bundle_t           buf_bundle;
    res_item_t             out_item;

    assign cfg_ready = 1'b1;

    vrce_core #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS),
        .LOAD_BITS  (LOAD_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_action      (s_axis_tuser),
        .in_city_a      (s_axis_tdata[7:0]),
        .in_city_b      (s_axis_tdata[15:8]),
        .in_entry_value (s_axis_tdata[31:16]),
        .in_route_end   (s_axis_tlast),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .dist_we        (dist_we),
        .dist_waddr     (dist_waddr),
        .dist_wdata     (dist_wdata),
        .dist_re        (dist_re),
        .dist_raddr_a   (dist_raddr_a),
        .dist_raddr_b   (dist_raddr_b),
        .dist_rdata_a   (dist_rdata_a),
        .dist_rdata_b   (dist_rdata_b),
        .dem_we         (dem_we),
        .dem_waddr      (dem_waddr),
        .dem_wdata      (dem_wdata),
        .dem_re         (dem_re),
        .dem_raddr      (dem_raddr),
        .dem_rdata      (dem_rdata),
        .buf_free       (buf_free),
        .buf_push       (buf_push),
        .buf_bundle     (buf_bundle)
    );

    vrce_tables #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS),
        .LOAD_BITS  (LOAD_BITS)
    ) u_tables (
        .clk          (clk),
        .dist_we      (dist_we),
        .dist_waddr   (dist_waddr),
        .dist_wdata   (dist_wdata),
        .dist_re      (dist_re),
        .dist_raddr_a (dist_raddr_a),
        .dist_raddr_b (dist_raddr_b),
        .dist_rdata_a (dist_rdata_a),
        .dist_rdata_b (dist_rdata_b),
        .dem_we       (dem_we),
        .dem_waddr    (dem_waddr),
        .dem_wdata    (dem_wdata),
        .dem_re       (dem_re),
        .dem_raddr    (dem_raddr),
        .dem_rdata    (dem_rdata)
    );

    vrce_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (buf_push),
        .bundle    (buf_bundle),
        .free      (buf_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = out_item.value;
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.fin;

endmodule

/* verif/vehicle_route_cost_evaluator_tb.sv */
// Self-checking bench for vehicle_route_cost_evaluator: loads the distance and
// demand tables, streams routes and compares stops and totals with an in-bench
// route cost predictor. Depends on vrce_pkg and the RTL top level only.
module vehicle_route_cost_evaluator_tb;

    import vrce_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 360;
    localparam int LONG_VISITS    = 30;
    localparam int FLEET_SIZE     = 6;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_UNUSED;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic [15:0] leg_length [0:65535];
    logic [15:0] city_demand [0:255];
    logic [15:0] capacity_now = '0;
    logic [15:0] trip_load = '0;
    logic [7:0]  last_city = '0;
    logic [31:0] trip_total = '0;
    logic        at_depot = 1'b1;
    logic        route_open = 1'b0;

    res_item_t   stop_and_total_q [$];
    logic [7:0]  fleet_cities [FLEET_SIZE];

    int cycle_count = 0;
    int fail_count = 0;
    int requests_sent = 0;
    int visits_sent = 0;
    int routes_closed = 0;
    int overloads_seen = 0;
    int results_checked = 0;
    logic steady;

    vehicle_route_cost_evaluator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // city_a[7:0], city_b[15:8], entry_value[31:16]
        .s_axis_tuser  (s_axis_tuser),   // action[1:0]
        .s_axis_tlast  (s_axis_tlast),   // route_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // result_value[31:0]
        .m_axis_tuser  (m_axis_tuser),   // result_kind
        .m_axis_tlast  (m_axis_tlast),   // final_flag
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // a window that recurs with the cycle count runs both sides without idling
    assign steady = (cycle_count % 3000) >= 2200;

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run exceeded %0d cycles, %0d results outstanding",
                 $time, CYCLE_LIMIT, stop_and_total_q.size());
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_leg(logic [15:0] leg);
        logic [32:0] sum;
        sum = {1'b0, trip_total} + 33'(leg);
        trip_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void queue_result(logic kind, logic [31:0] value, logic fin);
        res_item_t item;
        item.kind  = kind;
        item.value = value;
        item.fin   = fin;
        stop_and_total_q.insert(stop_and_total_q.size(), item);
    endfunction

    function automatic void due_stop(logic [7:0] city);
        queue_result(KIND_STOP, VAL_W'(city), 1'b0);
        at_depot = (city == 8'd0);
    endfunction

    function automatic void trace_route_request(logic [1:0] act, logic [7:0] ca,
                                                logic [7:0] cb, logic [15:0] val,
                                                logic route_end);
        logic [16:0] trial_load;
        case (act)
            ACT_DIST:   leg_length[{ca, cb}] = val;
            ACT_DEMAND: city_demand[ca] = val;
            ACT_VISIT:
            begin
                visits_sent++;
                if (!route_open)
                begin
                    route_open = 1'b1;
                    due_stop(8'd0);
                end
                if (ca == 8'd0)
                begin
                    add_leg(leg_length[{last_city, 8'd0}]);
                    trip_load = '0;
                    if (!at_depot)
                        due_stop(8'd0);
                end
                else
                begin
                    trial_load = {1'b0, trip_load} + 17'(city_demand[ca]);
                    if (trial_load <= {1'b0, capacity_now})
                    begin
                        add_leg(leg_length[{last_city, ca}]);
                        trip_load = trial_load[15:0];
                    end
                    else
                    begin
                        // return to the depot first, then head out again
                        overloads_seen++;
                        add_leg(leg_length[{last_city, 8'd0}]);
                        add_leg(leg_length[{8'd0, ca}]);
                        trip_load = city_demand[ca];
                        if (!at_depot)
                            due_stop(8'd0);
                    end
                    due_stop(ca);
                end
                last_city = ca;
                if (route_end)
                begin
                    add_leg(leg_length[{ca, 8'd0}]);
                    if (!at_depot)
                        due_stop(8'd0);
                    queue_result(KIND_TOTAL, trip_total, 1'b1);
                    routes_closed++;
                    trip_load = '0;
                    last_city = '0;
                    trip_total = '0;
                    at_depot = 1'b1;
                    route_open = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- result check

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_item_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (stop_and_total_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual kind %0d value 0x%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                due = stop_and_total_q.pop_front();
                compare_field("result_kind", 32'(due.kind), 32'(m_axis_tuser));
                compare_field("result_value", due.value, m_axis_tdata);
                compare_field("final_flag", 32'(due.fin), 32'(m_axis_tlast));
                results_checked++;
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 38);
    end

    // ---------------------------------------------------------------- drivers

    // valid stays high after acceptance; the next call either idles or reuses it
    task automatic send_request(logic [1:0] act, logic [7:0] ca, logic [7:0] cb,
                                logic [15:0] val, logic route_end);
        while (!steady && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {val, cb, ca};
        s_axis_tlast  <= route_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        trace_route_request(act, ca, cb, val, route_end);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (stop_and_total_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [15:0] cap);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity_now = cap;
    endtask

    function automatic logic [15:0] pick_demand();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 16'($urandom_range(120));
        else if (roll < 90)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_fleet_city();
        if ($urandom_range(4) == 0)
            return 8'd0;
        return fleet_cities[$urandom_range(FLEET_SIZE - 1, 1)];
    endfunction

    task automatic rewrite_fleet_entry();
        if ($urandom_range(1) == 0)
            send_request(ACT_DIST, fleet_cities[$urandom_range(FLEET_SIZE - 1)],
                         fleet_cities[$urandom_range(FLEET_SIZE - 1)], 16'($urandom),
                         1'($urandom));
        else
            send_request(ACT_DEMAND, fleet_cities[$urandom_range(FLEET_SIZE - 1)],
                         8'($urandom), pick_demand(), 1'($urandom));
    endtask

    // ---------------------------------------------------------------- tests

    // visits stay inside a small fleet of cities whose every entry is written
    task automatic load_fleet_tables();
        logic [7:0] pick;
        logic       dup;
        fleet_cities[0] = 8'd0;
        fleet_cities[1] = 8'd255;
        for (int i = 2; i < FLEET_SIZE; i++)
        begin
            do
            begin
                pick = 8'($urandom_range(254, 1));
                dup  = 1'b0;
                for (int j = 2; j < i; j++)
                begin
                    if (fleet_cities[j] == pick)
                        dup = 1'b1;
                end
            end
            while (dup);
            fleet_cities[i] = pick;
        end
        for (int r = 0; r < FLEET_SIZE; r++)
        begin
            send_request(ACT_DEMAND, fleet_cities[r], 8'd0, pick_demand(), 1'b0);
            for (int c = 0; c < FLEET_SIZE; c++)
                send_request(ACT_DIST, fleet_cities[r], fleet_cities[c], 16'($urandom), 1'b0);
        end
    endtask

    task automatic check_capacity_rules();
        logic [7:0] light;
        logic [7:0] heavy;
        logic [7:0] bulky;
        light = fleet_cities[2];
        heavy = fleet_cities[3];
        bulky = fleet_cities[4];
        write_capacity(16'd100);
        send_request(ACT_DEMAND, light, 8'd0, 16'd40, 1'b0);
        send_request(ACT_DEMAND, heavy, 8'd0, 16'd70, 1'b0);
        send_request(ACT_DEMAND, bulky, 8'hFF, 16'd150, 1'b0);
        send_request(ACT_DEMAND, 8'd255, 8'd0, 16'd60, 1'b0);
        send_request(ACT_DIST, 8'd255, 8'd0, 16'hFFFF, 1'b0);
        send_request(ACT_DIST, 8'd0, 8'd255, 16'h0000, 1'b0);
        // fitting city, then one that overflows the load after a stop
        send_request(ACT_VISIT, light, 8'd0, 16'd0, 1'b0);
        send_request(ACT_VISIT, heavy, 8'd0, 16'd0, 1'b0);
        // depot, then the same depot again which must not repeat a stop
        send_request(ACT_VISIT, 8'd0, 8'd0, 16'd0, 1'b0);
        send_request(ACT_VISIT, 8'd0, 8'd0, 16'd0, 1'b0);
        // demand alone beyond capacity, straight from the depot
        send_request(ACT_VISIT, bulky, 8'd0, 16'd0, 1'b0);
        send_request(ACT_VISIT, 8'd255, 8'd0, 16'd0, 1'b1);
        // route that is only the depot
        send_request(ACT_VISIT, 8'd0, 8'hFF, 16'hFFFF, 1'b1);
        // unknown action must be dropped
        send_request(ACT_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        send_request(ACT_VISIT, 8'd255, 8'd0, 16'd0, 1'b1);
    endtask

    task automatic run_random_routes(int budget);
        int sent;
        int roll;
        int hops;
        sent = 0;
        while (sent < budget)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
            begin
                hops = $urandom_range(6, 1);
                for (int k = 0; k < hops; k++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        rewrite_fleet_entry();
                        sent++;
                    end
                    send_request(ACT_VISIT, pick_fleet_city(), 8'($urandom), 16'($urandom),
                                 (k == hops - 1) && ($urandom_range(9) != 0));
                    sent++;
                end
            end
            else if (roll < 80)
            begin
                rewrite_fleet_entry();
                sent++;
            end
            else if (roll < 95)
            begin
                send_request(2'($urandom_range(1)), 8'($urandom), 8'($urandom),
                             16'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                send_request(ACT_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom),
                             1'($urandom));
                sent++;
            end
        end
    endtask

    task automatic check_random_capacities();
        write_capacity(16'hFFFF);
        run_random_routes(RANDOM_ITEMS / 3);
        write_capacity(16'($urandom_range(400, 100)));
        run_random_routes(RANDOM_ITEMS / 3);
        write_capacity(16'($urandom_range(60)));
        run_random_routes(RANDOM_ITEMS / 3);
    endtask

    // every visit overflows; each after the first pays the full round trip at the largest leg lengths
    task automatic check_long_trips();
        write_capacity(16'd0);
        send_request(ACT_DIST, 8'd255, 8'd0, 16'hFFFF, 1'b0);
        send_request(ACT_DIST, 8'd0, 8'd255, 16'hFFFF, 1'b0);
        send_request(ACT_DEMAND, 8'd255, 8'd0, 16'd1, 1'b0);
        for (int k = 0; k < LONG_VISITS; k++)
            send_request(ACT_VISIT, 8'd255, 8'd0, 16'd0, k == LONG_VISITS - 1);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_fleet_tables();
        check_capacity_rules();
        check_random_capacities();
        check_long_trips();
        settle_block();
        $display("covered %0d requests, %0d visits, %0d routes, %0d overloaded visits",
                 requests_sent, visits_sent, routes_closed, overloads_seen);
        $display("checked %0d stops and totals, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/vrce_pkg.sv
rtl/vrce_tables.sv
rtl/vrce_result_buf.sv
rtl/vrce_core.sv
rtl/vehicle_route_cost_evaluator.sv
verif/vehicle_route_cost_evaluator_tb.sv
